// ===== src/ata_pkg.sv =====
// Shared constants, types and the arctangent table for the tilt angle pipeline.
package ata_pkg;

  localparam int unsigned SampleWidth  = 10;
  localparam int unsigned CordicStages = 16;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned AngleQ       = 30;
  localparam int unsigned OutWidth     = 11;
  localparam int unsigned OutMax       = 900;

  // Widths of a magnitude, the sum of two squares, and the Q.32 radicand.
  localparam int unsigned MagWidth  = SampleWidth;
  localparam int unsigned SumWidth  = 2 * MagWidth + 1;
  localparam int unsigned RadWidth  = SumWidth + 2 * FracBits;
  localparam int unsigned RootWidth = (RadWidth + 1) / 2;
  // One root bit is produced by each root cell.
  localparam int unsigned RootSteps = RootWidth;
  localparam int unsigned RootIdxW  = $clog2(RootSteps);
  // CORDIC datapath: operands grow by at most a factor of about 1.65.
  localparam int unsigned CordW    = RootWidth + 3;
  localparam int unsigned AccW     = AngleQ + 3;
  localparam int unsigned StageIdxW = $clog2(CordicStages);

  // Output scaling: mag = floor(acc * 180000 / (314 * 2^30)).
  localparam longint unsigned ScaleNum = 64'd180000;
  // Since 314 * 2^30 = 157 * 2^31 and 157 * 427445 = 2^26 + 1, the quotient is
  // floor(floor(p / 2^31) * 427445 / 2^26) for every product that can occur.
  localparam int unsigned ScaleRecip  = 427445;
  localparam int unsigned ScaleRecipW = 19;
  localparam int unsigned ScaleShift  = 26;

  typedef enum logic [1:0] {
    FUNC_Z   = 2'd0,
    FUNC_X   = 2'd1,
    FUNC_Y   = 2'd2,
    FUNC_BAD = 2'd3
  } func_e;

  // Flags that ride alongside each request through the pipeline.
  typedef struct packed {
    logic valid;
    logic neg;
    logic bad;
    logic dzero;
    logic nzero;
  } side_t;

  // Root cell state.
  typedef struct packed {
    logic [RadWidth-1:0]  rem;
    logic [RootWidth-1:0] root;
    logic [RadWidth-1:0]  plain;
    logic                 root_is_num;
  } root_t;

  // CORDIC cell state.
  typedef struct packed {
    logic signed [CordW-1:0] cx;
    logic signed [CordW-1:0] cy;
    logic signed [AccW-1:0]  acc;
  } cord_t;

  function automatic logic signed [AccW-1:0] atan_entry(input int unsigned i);
    logic signed [AccW-1:0] r;
    r = '0;
    case (i)
      0:  r = AccW'(843314857);
      1:  r = AccW'(497837829);
      2:  r = AccW'(263043837);
      3:  r = AccW'(133525159);
      4:  r = AccW'(67021687);
      5:  r = AccW'(33543516);
      6:  r = AccW'(16775851);
      7:  r = AccW'(8388437);
      8:  r = AccW'(4194283);
      9:  r = AccW'(2097149);
      10: r = AccW'(1048576);
      default: begin
        if (i <= AngleQ) r = AccW'(64'd1 << (AngleQ - i));
      end
    endcase
    return r;
  endfunction

  // Shift toward zero.
  function automatic logic signed [CordW-1:0] shr_tz(input logic signed [CordW-1:0] v,
                                                      input int unsigned i);
    logic [CordW-1:0] m;
    m = v[CordW-1] ? CordW'(-v) : v;
    m = m >> i;
    return v[CordW-1] ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ===== src/ata_root_cell.sv =====
// One cell of the pipelined bitwise square root: produces one root bit a cycle while enabled.
module ata_root_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [ata_pkg::RootIdxW-1:0]  step_i,
  input  ata_pkg::side_t                side_i,
  input  ata_pkg::root_t                st_i,
  output ata_pkg::side_t                side_o,
  output ata_pkg::root_t                st_o
);
  localparam int unsigned W   = ata_pkg::RadWidth;
  localparam int unsigned ShW = ata_pkg::RootIdxW + 1;

  ata_pkg::side_t side_q;
  ata_pkg::root_t st_q, st_d;
  logic [W+1:0] trial;
  logic [W+1:0] top;
  logic [ShW-1:0] sh;

  // Restoring root step on the bit pair selected by this cell.
  always_comb begin
    sh    = ShW'(2 * (ata_pkg::RootSteps - 1 - step_i));
    st_d  = st_i;
    top   = (W+2)'(st_i.rem >> sh);
    trial = {st_i.root, 2'b01};
    st_d.root = {st_i.root[ata_pkg::RootWidth-2:0], 1'b0};
    if (top >= trial) begin
      st_d.rem  = st_i.rem - W'(trial << sh);
      st_d.root = {st_i.root[ata_pkg::RootWidth-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q <= st_d;
  end

  assign side_o = side_q;
  assign st_o   = st_q;
endmodule

// ===== src/ata_cordic_cell.sv =====
// One vectoring CORDIC cell: one micro-rotation a cycle while enabled.
module ata_cordic_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [ata_pkg::StageIdxW-1:0] step_i,
  input  ata_pkg::side_t                side_i,
  input  ata_pkg::cord_t                st_i,
  output ata_pkg::side_t                side_o,
  output ata_pkg::cord_t                st_o
);
  ata_pkg::side_t side_q;
  ata_pkg::cord_t st_q, st_d;
  logic signed [ata_pkg::CordW-1:0] dx, dy;

  // Rotate toward the x axis and accumulate the angle.
  always_comb begin
    dx = ata_pkg::shr_tz(st_i.cy, step_i);
    dy = ata_pkg::shr_tz(st_i.cx, step_i);
    st_d = st_i;
    if (st_i.cy > 0) begin
      st_d.cx  = st_i.cx + dx;
      st_d.cy  = st_i.cy - dy;
      st_d.acc = st_i.acc + ata_pkg::atan_entry(step_i);
    end else begin
      st_d.cx  = st_i.cx - dx;
      st_d.cy  = st_i.cy + dy;
      st_d.acc = st_i.acc - ata_pkg::atan_entry(step_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q <= st_d;
  end

  assign side_o = side_q;
  assign st_o   = st_q;
endmodule

// ===== src/accel_tilt_angle.sv =====
// Top level of the pipelined accelerometer tilt angle unit.
// Accepts one sample a cycle while in_ready_o is high and returns one angle per sample, in order.
// A request is captured by the first root cell at the edge that accepts it,
// and its result is presented after it passes one root cell per
// root bit (RootSteps, 27), one CORDIC cell per stage (CordicStages, 16), the
// scaling multiply register and the output register, 45 registers in all.
// The whole chain advances together, so it stalls as a unit when the output
// request is not taken and the output register is full.
module accel_tilt_angle (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [ata_pkg::SampleWidth-1:0] accel_x_i,
  input  logic signed [ata_pkg::SampleWidth-1:0] accel_y_i,
  input  logic signed [ata_pkg::SampleWidth-1:0] accel_z_i,
  input  logic [1:0]                             func_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [ata_pkg::OutWidth-1:0]    tilt_angle_o,
  output logic                                   invalid_result_o
);
  localparam int unsigned SW = ata_pkg::SampleWidth;
  localparam int unsigned RW = ata_pkg::RadWidth;
  localparam int unsigned RS = ata_pkg::RootSteps;
  localparam int unsigned CS = ata_pkg::CordicStages;
  localparam int unsigned CW = ata_pkg::CordW;
  localparam int unsigned PW = ata_pkg::AccW + 18;
  localparam int unsigned QW = PW - ata_pkg::AngleQ - 1;
  localparam int unsigned RPW = QW + ata_pkg::ScaleRecipW;

  logic en;
  logic out_full_q;

  // The whole chain moves when the output register is free or being emptied.
  assign en         = !out_full_q || out_ready_i;
  assign in_ready_o = en;

  // Input stage: magnitudes, squares and the radicand.
  logic [SW-1:0] mx, my, mz, ma, mb, mc;
  logic [ata_pkg::SumWidth-1:0] sum;
  ata_pkg::side_t side0;
  ata_pkg::root_t root0;
  ata_pkg::func_e fsel;

  always_comb begin
    mx = accel_x_i[SW-1] ? SW'(-accel_x_i) : SW'(accel_x_i);
    my = accel_y_i[SW-1] ? SW'(-accel_y_i) : SW'(accel_y_i);
    mz = accel_z_i[SW-1] ? SW'(-accel_z_i) : SW'(accel_z_i);
    fsel = ata_pkg::func_e'(func_i);
    side0 = '0;
    side0.valid = in_valid_i;
    root0 = '0;
    ma = mx;
    mb = my;
    mc = mz;
    case (fsel)
      ata_pkg::FUNC_Z: begin
        ma = mx; mb = my; mc = mz;
        root0.root_is_num = 1'b1;
        side0.neg = accel_z_i[SW-1];
      end
      ata_pkg::FUNC_X: begin
        ma = my; mb = mz; mc = mx;
        side0.neg = accel_x_i[SW-1];
      end
      ata_pkg::FUNC_Y: begin
        ma = mx; mb = mz; mc = my;
        side0.neg = accel_y_i[SW-1];
      end
      default: begin
        side0.bad = 1'b1;
      end
    endcase
    sum = ata_pkg::SumWidth'(ma) * ata_pkg::SumWidth'(ma)
        + ata_pkg::SumWidth'(mb) * ata_pkg::SumWidth'(mb);
    root0.rem   = RW'(sum) << (2 * ata_pkg::FracBits);
    root0.plain = RW'(mc) << ata_pkg::FracBits;
  end

  // Root chain.
  ata_pkg::side_t     rside [RS+1];
  ata_pkg::root_t     rst   [RS+1];
  assign rside[0] = side0;
  assign rst[0]   = root0;

  for (genvar g = 0; g < RS; g++) begin : g_root
    ata_root_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .step_i(ata_pkg::RootIdxW'(g)),
      .side_i(rside[g]), .st_i(rst[g]),
      .side_o(rside[g+1]), .st_o(rst[g+1])
    );
  end

  // Hand-over to the CORDIC: numerator, divisor and special cases.
  logic [RW-1:0] nmag, dmag;
  ata_pkg::side_t cside [CS+1];
  ata_pkg::cord_t cst   [CS+1];

  always_comb begin
    if (rst[RS].root_is_num) begin
      nmag = RW'(rst[RS].root);
      dmag = rst[RS].plain;
    end else begin
      nmag = rst[RS].plain;
      dmag = RW'(rst[RS].root);
    end
    cside[0] = rside[RS];
    cside[0].nzero = (nmag == '0);
    cside[0].dzero = (dmag == '0);
    // With z as divisor, the sign comes from z; a zero divisor gives +900.
    if (rst[RS].root_is_num && dmag == '0) cside[0].neg = 1'b0;
    cst[0].cx  = $signed(CW'(dmag));
    cst[0].cy  = $signed(CW'(nmag));
    cst[0].acc = '0;
  end

  for (genvar g = 0; g < CS; g++) begin : g_cord
    ata_cordic_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .step_i(ata_pkg::StageIdxW'(g)),
      .side_i(cside[g]), .st_i(cst[g]),
      .side_o(cside[g+1]), .st_o(cst[g+1])
    );
  end

  // Scaling stage: multiply the accumulator by the scale numerator; a negative accumulator gives zero.
  ata_pkg::side_t sside_q;
  logic [ata_pkg::AccW+17:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sside_q <= '0;
    end else if (en) begin
      sside_q <= cside[CS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (cst[CS].acc[ata_pkg::AccW-1]) prod_q <= '0;
      else prod_q <= (ata_pkg::AccW+18)'(cst[CS].acc) * (ata_pkg::AccW+18)'(ata_pkg::ScaleNum);
    end
  end

  // Division by the constant denominator through a reciprocal, saturation, special cases and sign.
  logic [QW-1:0] qhi;
  logic [RPW-1:0] recip_prod;
  logic [ata_pkg::AccW+17:0] quot;
  logic [ata_pkg::OutWidth-1:0] mag;
  logic signed [ata_pkg::OutWidth-1:0] angle_d;
  logic inval_d;

  always_comb begin
    qhi = prod_q[PW-1:ata_pkg::AngleQ+1];
    recip_prod = RPW'(qhi) * RPW'(ata_pkg::ScaleRecip);
    quot = (ata_pkg::AccW+18)'(recip_prod >> ata_pkg::ScaleShift);
    mag = (quot > ata_pkg::OutMax) ? ata_pkg::OutWidth'(ata_pkg::OutMax)
                                   : ata_pkg::OutWidth'(quot);
    inval_d = 1'b0;
    if (sside_q.bad || (sside_q.nzero && sside_q.dzero)) begin
      mag = '0;
      inval_d = 1'b1;
    end else if (sside_q.dzero) begin
      mag = ata_pkg::OutWidth'(ata_pkg::OutMax);
    end else if (sside_q.nzero) begin
      mag = '0;
    end
    angle_d = sside_q.neg ? -$signed(mag) : $signed(mag);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_full_q <= 1'b0;
    end else if (en) begin
      out_full_q <= sside_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tilt_angle_o     <= angle_d;
      invalid_result_o <= inval_d;
    end
  end

  assign out_valid_o = out_full_q;
endmodule
